// ----- design/rrss_pkg.sv -----
// ----------------------------------------------------------------------------
// rrss_pkg
// Shared types and constants of the round-robin slice scheduler.
// ----------------------------------------------------------------------------
package rrss_pkg;

  localparam int MAX_PROCS_DEFAULT  = 64;
  localparam int BURST_BITS_DEFAULT = 16;

  localparam int REQ_W       = 2;
  localparam int BURST_W     = 16;
  localparam int QUANTUM_W   = 16;
  localparam int PROC_IDX_W  = 6;
  localparam int SLICE_W     = 16;
  localparam int ELAPSED_W   = 22;
  localparam int STATUS_W    = 2;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(4);

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_RUN    = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

endpackage

// ----- design/round_robin_slice_scheduler_top.sv -----
// A request's result word is registered when the execute state fires; a result
// waiting on the output holds that state, not the next request's acceptance.
// One request is in flight at a time: the pick and memory read share the accept
// cycle, the read-modify-write of remaining time is done in the execute state.
// Reset clears the active mask, process count, pointer, elapsed time and sets
// quantum to 4; the remaining-time memory is not cleared (written before use).
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler_top
// Round-robin time-slice scheduler with remaining times held in a RAM.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler_top #(
  parameter int MAX_PROCS  = rrss_pkg::MAX_PROCS_DEFAULT,
  parameter int BURST_BITS = rrss_pkg::BURST_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rrss_pkg::QUANTUM_W-1:0] cfg_data,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rrss_pkg::REQ_W-1:0]     req_type,
  input  logic [rrss_pkg::BURST_W-1:0]   burst,

  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rrss_pkg::PROC_IDX_W-1:0] proc_index,
  output logic [rrss_pkg::SLICE_W-1:0]   slice_len,
  output logic                           finished,
  output logic [rrss_pkg::ELAPSED_W-1:0] turnaround,
  output logic                           all_done,
  output logic [rrss_pkg::STATUS_W-1:0]  status
);

  localparam int IW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int BB = BURST_BITS;
  localparam int WW = (BB > rrss_pkg::QUANTUM_W) ? BB : rrss_pkg::QUANTUM_W;
  localparam int EW = rrss_pkg::ELAPSED_W;

  rrss_pkg::state_t state, state_next;

  logic [rrss_pkg::QUANTUM_W-1:0] quantum;
  logic [MAX_PROCS-1:0]           active_mask, active_mask_next;
  logic [CW-1:0]                  process_count, process_count_next;
  logic [IW-1:0]                  next_pointer, next_pointer_next;
  logic [EW-1:0]                  elapsed_time, elapsed_time_next;

  logic [rrss_pkg::REQ_W-1:0]   req_reg;
  logic [rrss_pkg::BURST_W-1:0] burst_reg;
  logic [IW-1:0]                sel_reg;
  logic                         found_reg;

  logic [IW-1:0] pick_sel;
  logic          pick_found;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [BB-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [BB-1:0] ram_rdata;

  logic                         accept;
  logic                         fire;
  logic [rrss_pkg::QUANTUM_W-1:0] q_eff;
  logic [WW-1:0]                rem_w;
  logic [WW-1:0]                q_w;
  logic [WW-1:0]                slice_w;
  logic [BB-1:0]                rem_new;
  logic [EW:0]                  elapsed_sum;
  logic [EW-1:0]                elapsed_sat;
  logic [WW-1:0]                burst_w;
  logic [BB-1:0]                burst_t;

  logic [rrss_pkg::PROC_IDX_W-1:0] res_index;
  logic [rrss_pkg::SLICE_W-1:0]    res_slice;
  logic                            res_fin;
  logic [EW-1:0]                   res_ta;
  rrss_pkg::status_t               res_status;

  rrss_pick #(
    .N (MAX_PROCS)
  ) u_pick (
    .mask  (active_mask),
    .ptr   (next_pointer),
    .sel   (pick_sel),
    .found (pick_found)
  );

  rrss_ram #(
    .WIDTH (BB),
    .DEPTH (MAX_PROCS)
  ) u_rem_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == rrss_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign fire      = (state == rrss_pkg::ST_EXEC) && (!out_valid || out_ready);

  // read the picked entry on accept, hold the address while waiting to finish
  assign ram_raddr = (state == rrss_pkg::ST_IDLE) ? pick_sel : sel_reg;

  // slice and elapsed datapath
  assign q_eff       = (quantum == '0) ? rrss_pkg::QUANTUM_W'(1) : quantum;
  assign rem_w       = WW'(ram_rdata);
  assign q_w         = WW'(q_eff);
  assign slice_w     = (rem_w < q_w) ? rem_w : q_w;
  assign rem_new     = ram_rdata - BB'(slice_w);
  assign elapsed_sum = {1'b0, elapsed_time} + (EW + 1)'(slice_w);
  assign elapsed_sat = elapsed_sum[EW] ? {EW{1'b1}} : elapsed_sum[EW-1:0];
  assign burst_w     = WW'(burst_reg);
  assign burst_t     = burst_w[BB-1:0];

  always_comb begin
    state_next         = state;
    active_mask_next   = active_mask;
    process_count_next = process_count;
    next_pointer_next  = next_pointer;
    elapsed_time_next  = elapsed_time;
    ram_we             = 1'b0;
    ram_waddr          = sel_reg;
    ram_wdata          = rem_new;
    res_index          = '0;
    res_slice          = '0;
    res_fin            = 1'b0;
    res_ta             = '0;
    res_status         = rrss_pkg::STAT_OK;

    unique case (rrss_pkg::req_t'(req_reg))
      rrss_pkg::REQ_CLEAR: begin
        active_mask_next   = '0;
        process_count_next = '0;
        next_pointer_next  = '0;
        elapsed_time_next  = '0;
      end
      rrss_pkg::REQ_APPEND: begin
        if (process_count >= CW'(MAX_PROCS)) begin
          res_status = rrss_pkg::STAT_FULL;
        end else begin
          ram_we    = fire;
          ram_waddr = process_count[IW-1:0];
          ram_wdata = burst_t;
          active_mask_next[process_count[IW-1:0]] = (burst_t != '0);
          process_count_next = process_count + CW'(1);
        end
      end
      rrss_pkg::REQ_RUN: begin
        if (!found_reg) begin
          res_status = rrss_pkg::STAT_EMPTY;
        end else begin
          ram_we            = fire;
          elapsed_time_next = elapsed_sat;
          res_index         = rrss_pkg::PROC_IDX_W'(sel_reg);
          res_slice         = rrss_pkg::SLICE_W'(slice_w);
          if (rem_new == '0) begin
            active_mask_next[sel_reg] = 1'b0;
            res_fin = 1'b1;
            res_ta  = elapsed_sat;
          end
          next_pointer_next = (sel_reg == IW'(MAX_PROCS - 1)) ? '0 : sel_reg + IW'(1);
        end
      end
      default: begin
        // undefined request: no state change
      end
    endcase

    unique case (state)
      rrss_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = rrss_pkg::ST_EXEC;
        end
      end
      rrss_pkg::ST_EXEC: begin
        if (fire) begin
          state_next = rrss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rrss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum       <= rrss_pkg::QUANTUM_RESET;
      active_mask   <= '0;
      process_count <= '0;
      next_pointer  <= '0;
      elapsed_time  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        quantum <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        active_mask   <= active_mask_next;
        process_count <= process_count_next;
        next_pointer  <= next_pointer_next;
        elapsed_time  <= elapsed_time_next;
        out_valid     <= 1'b1;
      end
    end
  end

  // request word and pick result, captured on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      req_reg   <= req_type;
      burst_reg <= burst;
      sel_reg   <= pick_sel;
      found_reg <= pick_found;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (fire) begin
      proc_index <= res_index;
      slice_len  <= res_slice;
      finished   <= res_fin;
      turnaround <= res_ta;
      all_done   <= ~|active_mask_next;
      status     <= res_status;
    end
  end

endmodule

// ----- design/rrss_ram.sv -----
// ----------------------------------------------------------------------------
// rrss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/rrss_pick.sv -----
// ----------------------------------------------------------------------------
// rrss_pick
// Round-robin picker: first set bit of the active mask at or above the
// pointer, else the first set bit from the bottom.
// ----------------------------------------------------------------------------
module rrss_pick #(
  parameter int N = 64
) (
  input  logic [N-1:0]         mask,
  input  logic [$clog2(N)-1:0] ptr,
  output logic [$clog2(N)-1:0] sel,
  output logic                 found
);

  localparam int IW = $clog2(N);

  logic [IW-1:0] hi_sel;
  logic          hi_found;
  logic [IW-1:0] lo_sel;

  // scan downward so the lowest matching index wins
  always_comb begin
    hi_sel   = '0;
    hi_found = 1'b0;
    lo_sel   = '0;
    found    = 1'b0;
    for (int j = N - 1; j >= 0; j--) begin
      if (mask[j]) begin
        lo_sel = IW'(j);
        found  = 1'b1;
        if (j >= int'(ptr)) begin
          hi_sel   = IW'(j);
          hi_found = 1'b1;
        end
      end
    end
    sel = hi_found ? hi_sel : lo_sel;
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the round-robin slice scheduler. A scoreboard keeps
// its own copy of the process table and predicts one result word per request;
// plain tasks drive clear/append/run sessions with random bursts and gaps.
// ----------------------------------------------------------------------------
module tb;
  import rrss_pkg::*;

  localparam int NPROC = MAX_PROCS_DEFAULT;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASE_ITEMS = 300;
  localparam int RUN_CAP = 80;
  localparam int LIMIT_CYCLES = 1000000;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  typedef struct packed {
    logic [PROC_IDX_W-1:0] proc_index;
    logic [SLICE_W-1:0]    slice_len;
    logic                  finished;
    logic [ELAPSED_W-1:0]  turnaround;
    logic                  all_done;
    status_t               status;
  } slice_result_t;

  class slice_scoreboard;
    logic [QUANTUM_W-1:0]  quantum;
    logic [BURST_W-1:0]    remaining [NPROC];
    logic [NPROC-1:0]      active;
    int unsigned           proc_count;
    logic [PROC_IDX_W-1:0] next_ptr;
    logic [ELAPSED_W-1:0]  elapsed;
    slice_result_t         expected_q [$];
    int unsigned           errors;
    int unsigned           n_req [4];
    int unsigned           n_finished, n_full, n_empty;

    function new();
      quantum = QUANTUM_RESET;
      active = '0;
      proc_count = 0;
      next_ptr = '0;
      elapsed = '0;
      errors = 0;
      n_finished = 0;
      n_full = 0;
      n_empty = 0;
      foreach (n_req[i]) n_req[i] = 0;
      foreach (remaining[i]) remaining[i] = '0;
    endfunction

    function void set_quantum(logic [QUANTUM_W-1:0] q);
      quantum = q;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // predict the word caused by one accepted request
    function void note_request(logic [REQ_W-1:0] req, logic [BURST_W-1:0] b);
      slice_result_t         r;
      logic [QUANTUM_W-1:0]  q;
      logic [PROC_IDX_W-1:0] j, sel;
      logic [SLICE_W-1:0]    sl;
      logic [ELAPSED_W:0]    sum;
      bit                    found;
      int                    i;
      r = '0;
      r.status = STAT_OK;
      found = 0;
      sel = '0;
      n_req[req]++;
      case (req)
        REQ_CLEAR: begin
          active = '0;
          proc_count = 0;
          next_ptr = '0;
          elapsed = '0;
        end
        REQ_APPEND: begin
          if (proc_count >= NPROC) begin
            r.status = STAT_FULL;
            n_full++;
          end else begin
            remaining[proc_count] = b;
            active[proc_count] = (b != '0);
            proc_count++;
          end
        end
        REQ_RUN: begin
          // cyclic search from the pointer, first active entry wins
          for (i = 0; i < NPROC; i++) begin
            j = next_ptr + PROC_IDX_W'(i);
            if (!found && active[j]) begin
              sel = j;
              found = 1;
            end
          end
          if (!found) begin
            r.status = STAT_EMPTY;
            n_empty++;
          end else begin
            q = (quantum == '0) ? QUANTUM_W'(1) : quantum;
            sl = (remaining[sel] < q) ? remaining[sel] : q;
            remaining[sel] = remaining[sel] - sl;
            sum = {1'b0, elapsed} + (ELAPSED_W+1)'(sl);
            elapsed = (sum > ELAPSED_MAX) ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
            r.proc_index = sel;
            r.slice_len = sl;
            if (remaining[sel] == '0) begin
              active[sel] = 1'b0;
              r.finished = 1'b1;
              r.turnaround = elapsed;
              n_finished++;
            end
            next_ptr = sel + 1'b1;
          end
        end
        default: ;
      endcase
      r.all_done = (active == '0);
      expected_q.push_back(r);
    endfunction

    function void check_result(slice_result_t got);
      slice_result_t e;
      if (expected_q.size() == 0) begin
        $error("result word with no request pending: proc_index=%0d slice_len=%0d",
               got.proc_index, got.slice_len);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.proc_index !== e.proc_index) begin
        $error("proc_index: expected %0d, got %0d", e.proc_index, got.proc_index);
        errors++;
      end
      if (got.slice_len !== e.slice_len) begin
        $error("slice_len: expected %0d, got %0d", e.slice_len, got.slice_len);
        errors++;
      end
      if (got.finished !== e.finished) begin
        $error("finished: expected %0d, got %0d", e.finished, got.finished);
        errors++;
      end
      if (got.turnaround !== e.turnaround) begin
        $error("turnaround: expected %0d, got %0d", e.turnaround, got.turnaround);
        errors++;
      end
      if (got.all_done !== e.all_done) begin
        $error("all_done: expected %0d, got %0d", e.all_done, got.all_done);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [QUANTUM_W-1:0]   cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [REQ_W-1:0]       req_type;
  logic [BURST_W-1:0]     burst;
  logic                   out_valid;
  logic                   out_ready;
  logic [PROC_IDX_W-1:0]  proc_index;
  logic [SLICE_W-1:0]     slice_len;
  logic                   finished;
  logic [ELAPSED_W-1:0]   turnaround;
  logic                   all_done;
  logic [STATUS_W-1:0]    status;

  slice_scoreboard sb;
  slice_result_t   got_word;
  bit              steady;
  int              stall_left;
  int unsigned     items_sent;
  int unsigned     n_cfg;
  int unsigned     cycle_count;

  round_robin_slice_scheduler_top uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .burst      (burst),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .proc_index (proc_index),
    .slice_len  (slice_len),
    .finished   (finished),
    .turnaround (turnaround),
    .all_done   (all_done),
    .status     (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BURST_W-1:0] pick_burst(int unsigned qe);
    int r;
    int unsigned hi;
    r = $urandom_range(0, 99);
    hi = (qe * 3 > 65535) ? 65535 : qe * 3;
    if (r < 10) return '0;
    if (r < 80) return BURST_W'($urandom_range(1, hi));
    if (r < 92) return BURST_W'($urandom_range(1, qe));
    return BURST_W'($urandom_range(0, 65535));
  endfunction

  // output side: check accepted words, then pick next ready
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_word.proc_index = proc_index;
      got_word.slice_len  = slice_len;
      got_word.finished   = finished;
      got_word.turnaround = turnaround;
      got_word.all_done   = all_done;
      got_word.status     = status_t'(status);
      sb.check_result(got_word);
    end
    if (steady) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 30) begin
      out_ready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count, sb.pending());
      $display("** round_robin_slice_scheduler_top: FAILED **");
      $finish;
    end
  end

  task automatic idle_in();
    int n;
    n = steady ? 0 : pick_gap();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_req(input logic [REQ_W-1:0] req, input logic [BURST_W-1:0] b);
    in_valid <= 1'b1;
    req_type <= req;
    burst <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, b);
    items_sent++;
    idle_in();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_quantum(input logic [QUANTUM_W-1:0] q);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= q;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_quantum(q);
    n_cfg++;
  endtask

  // clear, append (a full table if asked), run slices until all done or capped
  task automatic run_session(input int unsigned qe, input bit fill_table);
    int n, r, runs;
    steady = ($urandom_range(0, 9) == 0);
    if (fill_table) n = NPROC + 1;
    else if ($urandom_range(0, 99) < 6) n = NPROC + $urandom_range(0, 3);
    else n = $urandom_range(1, 10);
    send_req(REQ_CLEAR, BURST_W'($urandom));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 3) send_req(REQ_RUN, BURST_W'($urandom));
      if (n > NPROC) send_req(REQ_APPEND, BURST_W'($urandom_range(0, qe)));
      else send_req(REQ_APPEND, pick_burst(qe));
    end
    if ($urandom_range(0, 99) < 5) wait_drained();
    runs = 0;
    while (sb.active != '0 && runs < RUN_CAP) begin
      r = $urandom_range(0, 99);
      if (r < 4) send_req(REQ_UNUSED, BURST_W'($urandom));
      else if (r < 7) send_req(REQ_APPEND, pick_burst(qe));
      else if (r < 8) send_req(REQ_CLEAR, BURST_W'($urandom));
      else send_req(REQ_RUN, BURST_W'($urandom));
      runs++;
    end
    repeat ($urandom_range(0, 2)) send_req(REQ_RUN, BURST_W'($urandom));
  endtask

  initial begin
    int unsigned directed_count, phase, phase_start, qe;
    logic [QUANTUM_W-1:0] q;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    req_type <= REQ_CLEAR;
    burst <= '0;
    out_ready <= 1'b0;
    steady = 0;
    stall_left = 0;
    items_sent = 0;
    n_cfg = 0;
    cycle_count = 0;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset quantum of four first
    send_req(REQ_RUN, 16'hFFFF);
    send_req(REQ_UNUSED, 16'h0000);
    send_req(REQ_APPEND, 16'hFFFF);
    send_req(REQ_APPEND, 16'h0000);  // zero burst takes an index, never runs
    send_req(REQ_APPEND, 16'd5);
    send_req(REQ_APPEND, 16'd1);
    send_req(REQ_UNUSED, 16'hA5A5);
    repeat (5) send_req(REQ_RUN, 16'h5A5A);
    send_req(REQ_CLEAR, 16'hFFFF);
    send_req(REQ_RUN, 16'h0000);
    write_quantum('0);               // zero quantum acts as one
    send_req(REQ_APPEND, 16'd3);
    repeat (4) send_req(REQ_RUN, 16'h0000);
    write_quantum('1);
    send_req(REQ_CLEAR, 16'h0000);
    send_req(REQ_APPEND, 16'hFFFF);
    send_req(REQ_APPEND, 16'hFFFF);
    repeat (2) send_req(REQ_RUN, 16'hFFFF);
    send_req(REQ_CLEAR, 16'h0000);
    directed_count = items_sent;

    phase = 0;
    while (items_sent - directed_count < RANDOM_ITEMS) begin
      case (phase % 5)
        0: q = 16'd1;
        1: q = 16'hFFFF;
        2: q = QUANTUM_W'($urandom_range(2, 16));
        3: q = QUANTUM_W'($urandom_range(17, 1000));
        default: q = QUANTUM_W'($urandom_range(1, 65535));
      endcase
      write_quantum(q);
      qe = (q == '0) ? 1 : q;
      phase_start = items_sent;
      run_session(qe, phase < 2);
      while (items_sent - phase_start < PHASE_ITEMS &&
             items_sent - directed_count < RANDOM_ITEMS)
        run_session(qe, 1'b0);
      phase++;
    end

    steady = 0;
    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d requests (%0d clear, %0d append, %0d run, %0d undefined) over %0d quanta",
             items_sent, sb.n_req[REQ_CLEAR], sb.n_req[REQ_APPEND], sb.n_req[REQ_RUN],
             sb.n_req[REQ_UNUSED], n_cfg + 1);
    $display("%0d processes completed, %0d appends to a full table, %0d runs with nothing active",
             sb.n_finished, sb.n_full, sb.n_empty);
    if (sb.errors == 0) begin
      $display("** round_robin_slice_scheduler_top: PASSED **");
    end else begin
      $display("** round_robin_slice_scheduler_top: FAILED **");
    end
    $finish;
  end
endmodule
